>>> src/psg_pkg.sv
package psg_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int PERIOD_W = 11;
  localparam logic [3:0] ATTEN_OFF = 4'hF;
  localparam logic [15:0] LFSR_SEED = 16'h8000;
  localparam logic [1:0] RATE_TONE2 = 2'd3;
  localparam logic [1:0] NOISE_CH = 2'd3;

  typedef struct packed {
    logic       tick;
    logic       latch;
    logic [1:0] chan;
    logic       attn;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic logic [PERIOD_W-1:0] noise_reload(input logic [1:0] sel,
                                                       input logic [PERIOD_W-1:0] p2);
    logic [PERIOD_W-1:0] r;
    case (sel)
      2'd0: r = PERIOD_W'(15);
      2'd1: r = PERIOD_W'(31);
      2'd2: r = PERIOD_W'(63);
      default: r = p2 - PERIOD_W'(1);
    endcase
    return r;
  endfunction

endpackage

>>> src/psg_front.sv
module psg_front #(
  parameter int DEPTH = psg_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_kind,
  input  logic [7:0]      in_data_byte,
  input  logic            pop,
  output psg_pkg::head_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  psg_pkg::item_t      mem [DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                push, do_pop;
  psg_pkg::item_t      cls;

  // classify the incoming byte
  always_comb begin
    cls.tick  = in_kind;
    cls.latch = in_data_byte[7];
    cls.chan  = in_data_byte[6:5];
    cls.attn  = in_data_byte[4];
    cls.data  = in_data_byte;
  end

  assign in_stall = (count_r == CW'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= cls;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = mem[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(DEPTH)) && !pop |=> count_r == CW'(DEPTH))
    else $error("full queue lost an entry");

  a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) && !in_valid |=> count_r == '0)
    else $error("empty queue gained an entry");

endmodule

>>> src/psg_back.sv
module psg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  psg_pkg::head_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_tone0_level,
  output logic            out_tone1_level,
  output logic            out_tone2_level,
  output logic            out_noise_level,
  output logic [3:0]      out_tone0_atten,
  output logic [3:0]      out_tone1_atten,
  output logic [3:0]      out_tone2_atten,
  output logic [3:0]      out_noise_atten
);

  localparam int PW = psg_pkg::PERIOD_W;

  logic [1:0]    lch_r, lch_nxt;
  logic          lattn_r, lattn_nxt;
  logic [3:0]    atten_r [4];
  logic [3:0]    atten_nxt [4];
  logic [PW-1:0] period_r [3];
  logic [PW-1:0] period_nxt [3];
  logic [3:0]    nib_r [3];
  logic [3:0]    nib_nxt [3];
  logic [PW-1:0] cnt_r [4];
  logic [PW-1:0] cnt_nxt [4];
  logic [3:0]    lvl_r, lvl_nxt;
  logic [15:0]   lfsr_r, lfsr_nxt;
  logic [1:0]    sel_r, sel_nxt;
  logic          mode_r, mode_nxt;
  logic          prior_r, prior_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          back_ready, take;
  logic [1:0]    ch;
  logic          attn;
  logic [15:0]   lfsr_sh;
  psg_pkg::item_t it;

  assign it         = head.item;
  assign back_ready = !out_valid_r || !out_stall;
  assign take       = head.valid && back_ready;
  assign pop        = take;

  assign ch   = it.latch ? it.chan : lch_r;
  assign attn = it.latch ? it.attn : lattn_r;

  always_comb begin
    if (prior_r != mode_r) begin
      lfsr_sh = psg_pkg::LFSR_SEED;
    end else if (mode_r) begin
      lfsr_sh = {lfsr_r[0] ^ lfsr_r[3], lfsr_r[15:1]};
    end else begin
      lfsr_sh = {lfsr_r[0], lfsr_r[15:1]};
    end
  end

  always_comb begin
    lch_nxt    = lch_r;
    lattn_nxt  = lattn_r;
    atten_nxt  = atten_r;
    period_nxt = period_r;
    nib_nxt    = nib_r;
    cnt_nxt    = cnt_r;
    lvl_nxt    = lvl_r;
    lfsr_nxt   = lfsr_r;
    sel_nxt    = sel_r;
    mode_nxt   = mode_r;
    prior_nxt  = prior_r;
    if (take && !it.tick) begin
      if (it.latch) begin
        lch_nxt   = it.chan;
        lattn_nxt = it.attn;
      end
      if (attn) begin
        atten_nxt[ch] = it.data[3:0];
      end else if (ch != psg_pkg::NOISE_CH) begin
        if (it.latch) begin
          nib_nxt[ch] = it.data[3:0];
        end else begin
          period_nxt[ch] = {it.data[6:0], nib_r[ch]};
        end
      end else begin
        sel_nxt  = it.data[1:0];
        mode_nxt = it.data[2];
      end
    end else if (take) begin
      for (int i = 0; i < 3; i++) begin
        if (atten_r[i] != psg_pkg::ATTEN_OFF) begin
          if (period_r[i] < PW'(2)) begin
            lvl_nxt[i] = 1'b1;
          end else if (cnt_r[i] == '0) begin
            cnt_nxt[i] = period_r[i] - PW'(1);
            lvl_nxt[i] = !lvl_r[i];
          end else begin
            cnt_nxt[i] = cnt_r[i] - PW'(1);
          end
        end
      end
      if (atten_r[3] != psg_pkg::ATTEN_OFF) begin
        if (sel_r == psg_pkg::RATE_TONE2 && period_r[2] < PW'(2)) begin
          lvl_nxt[3] = 1'b1;
        end else if (cnt_r[3] == '0) begin
          cnt_nxt[3] = psg_pkg::noise_reload(sel_r, period_r[2]);
          lfsr_nxt   = lfsr_sh;
          prior_nxt  = mode_r;
          lvl_nxt[3] = lfsr_sh[0];
        end else begin
          cnt_nxt[3] = cnt_r[3] - PW'(1);
        end
      end
    end
  end

  assign out_valid_nxt = take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lch_r       <= '0;
      lattn_r     <= 1'b0;
      atten_r     <= '{default: psg_pkg::ATTEN_OFF};
      period_r    <= '{default: '0};
      nib_r       <= '{default: '0};
      cnt_r       <= '{default: '0};
      lvl_r       <= '0;
      lfsr_r      <= psg_pkg::LFSR_SEED;
      sel_r       <= '0;
      mode_r      <= 1'b0;
      prior_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lch_r       <= lch_nxt;
      lattn_r     <= lattn_nxt;
      atten_r     <= atten_nxt;
      period_r    <= period_nxt;
      nib_r       <= nib_nxt;
      cnt_r       <= cnt_nxt;
      lvl_r       <= lvl_nxt;
      lfsr_r      <= lfsr_nxt;
      sel_r       <= sel_nxt;
      mode_r      <= mode_nxt;
      prior_r     <= prior_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_tone0_level <= lvl_nxt[0];
      out_tone1_level <= lvl_nxt[1];
      out_tone2_level <= lvl_nxt[2];
      out_noise_level <= lvl_nxt[3];
      out_tone0_atten <= atten_nxt[0];
      out_tone1_atten <= atten_nxt[1];
      out_tone2_atten <= atten_nxt[2];
      out_noise_atten <= atten_nxt[3];
    end
  end

  assign out_valid = out_valid_r;

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("noise register collapsed to zero");

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("popped transaction produced no result");

  a_silent_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    take && it.tick && atten_r[0] == psg_pkg::ATTEN_OFF |=> $stable(cnt_r[0]))
    else $error("silenced tone timer advanced");

  a_short_high: assert property (@(posedge clk) disable iff (!rst_n)
    take && it.tick && atten_r[1] != psg_pkg::ATTEN_OFF && period_r[1] < PW'(2)
    |=> lvl_r[1])
    else $error("short period did not force level high");

endmodule

>>> src/psg_tone_noise_generator_top.sv
// An accepted transaction is queued, then popped by the back end, which registers its result.
// Throughput: one transaction per cycle while out_stall is low; each tick advances the
// unsilenced timers and the noise register on a noise reload, in one pass of the back end.
// A short queue between front and back absorbs output stall; out_stall backs up into in_stall.
// Sync reset (rst_n low): attenuations 15, noise register 0x8000, else zero; output data not reset.
module psg_tone_noise_generator_top #(
  parameter int QUEUE_DEPTH = psg_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tone0_level,
  output logic       out_tone1_level,
  output logic       out_tone2_level,
  output logic       out_noise_level,
  output logic [3:0] out_tone0_atten,
  output logic [3:0] out_tone1_atten,
  output logic [3:0] out_tone2_atten,
  output logic [3:0] out_noise_atten
);

  psg_pkg::head_t head;
  logic           pop;

  psg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .pop          (pop),
    .head         (head)
  );

  psg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tone0_level (out_tone0_level),
    .out_tone1_level (out_tone1_level),
    .out_tone2_level (out_tone2_level),
    .out_noise_level (out_noise_level),
    .out_tone0_atten (out_tone0_atten),
    .out_tone1_atten (out_tone1_atten),
    .out_tone2_atten (out_tone2_atten),
    .out_noise_atten (out_noise_atten)
  );

endmodule

>>> verif/psg_tone_noise_generator_checker.sv
`timescale 1ns / 100ps

module psg_tone_noise_generator_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_tone0_level,
  input  logic       out_tone1_level,
  input  logic       out_tone2_level,
  input  logic       out_noise_level,
  input  logic [3:0] out_tone0_atten,
  input  logic [3:0] out_tone1_atten,
  input  logic [3:0] out_tone2_atten,
  input  logic [3:0] out_noise_atten,
  output int         mismatch_count,
  output int         pending_results
);

  typedef struct packed {
    logic [3:0]      level;
    logic [3:0][3:0] atten;
  } psg_snapshot_t;

  logic [1:0]                   sel_chan;
  logic                         sel_is_atten;
  logic [3:0]                   chan_atten [4];
  logic [psg_pkg::PERIOD_W-1:0] tone_divider [3];
  logic [3:0]                   divider_low [3];
  logic [psg_pkg::PERIOD_W-1:0] timer [4];
  logic [3:0]                   level;
  logic [15:0]                  noise_shreg;
  logic [1:0]                   noise_rate;
  logic                         noise_white;
  logic                         noise_white_prev;

  psg_snapshot_t       snapshot_q [$];

  task automatic clear_psg();
    sel_chan         = '0;
    sel_is_atten     = 1'b0;
    level            = '0;
    noise_shreg      = psg_pkg::LFSR_SEED;
    noise_rate       = '0;
    noise_white      = 1'b0;
    noise_white_prev = 1'b0;
    for (int ch = 0; ch < 4; ch++) begin
      chan_atten[ch] = psg_pkg::ATTEN_OFF;
      timer[ch]      = '0;
    end
    for (int ch = 0; ch < 3; ch++) begin
      tone_divider[ch] = '0;
      divider_low[ch]  = '0;
    end
  endtask

  task automatic apply_register_byte(input logic [7:0] b);
    if (b[7]) begin
      sel_chan     = b[6:5];
      sel_is_atten = b[4];
    end
    if (sel_is_atten) begin
      chan_atten[sel_chan] = b[3:0];
    end else if (sel_chan != psg_pkg::NOISE_CH) begin
      if (b[7]) begin
        divider_low[sel_chan] = b[3:0];
      end else begin
        tone_divider[sel_chan] = {b[6:0], divider_low[sel_chan]};
      end
    end else begin
      noise_rate  = b[1:0];
      noise_white = b[2];
    end
  endtask

  task automatic advance_generators();
    for (int ch = 0; ch < 3; ch++) begin
      if (chan_atten[ch] != psg_pkg::ATTEN_OFF) begin
        if (tone_divider[ch] < 2) begin
          level[ch] = 1'b1;
        end else if (timer[ch] == 0) begin
          timer[ch] = tone_divider[ch] - 1'b1;
          level[ch] = ~level[ch];
        end else begin
          timer[ch] = timer[ch] - 1'b1;
        end
      end
    end
    if (chan_atten[psg_pkg::NOISE_CH] != psg_pkg::ATTEN_OFF) begin
      if (noise_rate == psg_pkg::RATE_TONE2 && tone_divider[2] < 2) begin
        level[3] = 1'b1;
      end else if (timer[3] == 0) begin
        if (noise_rate == psg_pkg::RATE_TONE2) begin
          timer[3] = tone_divider[2] - 1'b1;
        end else begin
          timer[3] = (psg_pkg::PERIOD_W'(16) << noise_rate) - 1'b1;
        end
        if (noise_white_prev != noise_white) begin
          noise_shreg      = psg_pkg::LFSR_SEED;
          noise_white_prev = noise_white;
        end else if (noise_white) begin
          noise_shreg = {noise_shreg[0] ^ noise_shreg[3], noise_shreg[15:1]};
        end else begin
          noise_shreg = {noise_shreg[0], noise_shreg[15:1]};
        end
        level[3] = noise_shreg[0];
      end else begin
        timer[3] = timer[3] - 1'b1;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    psg_snapshot_t want;
    if (!rst_n) begin
      clear_psg();
      snapshot_q.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_kind) begin
          advance_generators();
        end else begin
          apply_register_byte(in_data_byte);
        end
        want.level = level;
        for (int ch = 0; ch < 4; ch++) begin
          want.atten[ch] = chan_atten[ch];
        end
        snapshot_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (snapshot_q.size() == 0) begin
          note_mismatch("unexpected transaction", 0, 1);
        end else begin
          want = snapshot_q.pop_front();
          if (out_tone0_level !== want.level[0]) note_mismatch("tone0_level", want.level[0], out_tone0_level);
          if (out_tone1_level !== want.level[1]) note_mismatch("tone1_level", want.level[1], out_tone1_level);
          if (out_tone2_level !== want.level[2]) note_mismatch("tone2_level", want.level[2], out_tone2_level);
          if (out_noise_level !== want.level[3]) note_mismatch("noise_level", want.level[3], out_noise_level);
          if (out_tone0_atten !== want.atten[0]) note_mismatch("tone0_atten", want.atten[0], out_tone0_atten);
          if (out_tone1_atten !== want.atten[1]) note_mismatch("tone1_atten", want.atten[1], out_tone1_atten);
          if (out_tone2_atten !== want.atten[2]) note_mismatch("tone2_atten", want.atten[2], out_tone2_atten);
          if (out_noise_atten !== want.atten[3]) note_mismatch("noise_atten", want.atten[3], out_noise_atten);
        end
      end
    end
    pending_results = snapshot_q.size();
  end

endmodule

>>> verif/psg_tone_noise_generator_top_tb.sv
`timescale 1ns / 100ps

module psg_tone_noise_generator_top_tb;

  localparam logic KIND_WRITE     = 1'b0;
  localparam logic KIND_TICK      = 1'b1;
  localparam int   RANDOM_ITEMS   = 1400;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   TAIL_CYCLES    = 8;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_kind         = 1'b0;
  logic [7:0] in_data_byte    = 8'h00;
  logic       out_stall       = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_tone0_level;
  logic       out_tone1_level;
  logic       out_tone2_level;
  logic       out_noise_level;
  logic [3:0] out_tone0_atten;
  logic [3:0] out_tone1_atten;
  logic [3:0] out_tone2_atten;
  logic [3:0] out_noise_atten;
  int         mismatch_count;
  int         pending_results;

  int         items_sent;
  bit         gapless_stretch;
  int         stall_left      = 0;
  int         quiet_cycles    = 0;

  always #5 clk = ~clk;

  psg_tone_noise_generator_top u_top (.*);

  psg_tone_noise_generator_checker u_checker (.*);

  always @(posedge clk) begin : stall_gen
    int pick;
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(50, 150);
        end else if (pick < 45) begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(0, 19);
        end else if (pick < 88) begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end else begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(7, 39);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (gapless_stretch || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (items_sent % 64 == 0) gapless_stretch = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_write(input logic [7:0] b);
    send_item(KIND_WRITE, b);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic random_sequence();
    int         pick;
    logic [1:0] ch;
    logic [3:0] nib;
    logic [6:0] hi;
    pick = $urandom_range(0, 99);
    ch   = 2'($urandom_range(0, 2));
    nib  = 4'($urandom_range(0, 15));
    if (pick < 30) begin
      send_ticks($urandom_range(4, 40));
    end else if (pick < 50) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) hi = '0;
      else if (pick < 9) hi = 7'($urandom_range(1, 3));
      else hi = 7'($urandom_range(0, 127));
      send_write({1'b1, ch, 1'b0, nib});
      send_write({1'b0, hi});
    end else if (pick < 65) begin
      ch  = 2'($urandom_range(0, 3));
      nib = ($urandom_range(0, 7) == 0) ? psg_pkg::ATTEN_OFF : 4'($urandom_range(0, 14));
      send_write({1'b1, ch, 1'b1, nib});
      if ($urandom_range(0, 3) == 0) send_write({1'b0, 7'($urandom_range(0, 127))});
    end else if (pick < 75) begin
      send_write({1'b1, psg_pkg::NOISE_CH, 1'b0, nib});
      if ($urandom_range(0, 2) == 0) send_write({1'b0, 7'($urandom_range(0, 127))});
    end else if (pick < 88) begin
      hi = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 3));
      send_write({1'b0, hi});
    end else begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bit halfway_drained;
    items_sent      = 0;
    gapless_stretch = 1'b0;
    halfway_drained = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_TICK, 8'h00);
    send_write(8'h90);
    send_item(KIND_TICK, 8'h00);
    send_write(8'h8F);
    send_write(8'h7F);
    send_item(KIND_TICK, 8'h00);
    send_write(8'h00);
    send_item(KIND_TICK, 8'h00);
    send_write(8'hA2);
    send_write(8'h00);
    send_write(8'hB0);
    send_ticks(3);
    send_write(8'hC1);
    send_write(8'h00);
    send_write(8'hD5);
    send_write(8'hF0);
    send_write(8'hE7);
    send_item(KIND_TICK, 8'h00);
    send_write(8'hE0);
    send_item(KIND_TICK, 8'h00);
    send_write(8'h05);
    send_item(KIND_TICK, 8'hFF);
    send_write(8'hFF);
    send_item(KIND_TICK, 8'h00);
    drain_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      random_sequence();
      if (!halfway_drained && items_sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        halfway_drained = 1'b1;
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/psg_pkg.sv
src/psg_front.sv
src/psg_back.sv
src/psg_tone_noise_generator_top.sv
verif/psg_tone_noise_generator_checker.sv
verif/psg_tone_noise_generator_top_tb.sv
